// File: hdl/nam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nam_pkg
// Shared types and constants for the node address map with aging.
// ----------------------------------------------------------------------------
package nam_pkg;

	localparam int NUM_SUBNETS      = 256;
	localparam int NODES_PER_SUBNET = 128;
	localparam int ADDR_BITS        = 32;
	localparam int AGE_BITS         = 8;

	localparam int NUM_ENTRIES = NUM_SUBNETS * NODES_PER_SUBNET;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int NODE_CNT_W  = $clog2(NODES_PER_SUBNET);
	localparam int SUB_W       = 8;
	localparam int NODE_W      = 7;
	localparam int OUT_ADDR_W  = 32;
	localparam int LIMIT_W     = 8;
	localparam int CMP_W       = (AGE_BITS > LIMIT_W) ? AGE_BITS : LIMIT_W;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
	localparam logic [LIMIT_W-1:0]  AGE_LIMIT_RESET = 8'd4;

	typedef enum logic [2:0] {
		OP_LOOKUP      = 3'd0,
		OP_SET_DERIVED = 3'd1,
		OP_CLR_DERIVED = 3'd2,
		OP_STORE       = 3'd3,
		OP_CLR_ADDR    = 3'd4,
		OP_AGE_TICK    = 3'd5,
		OP_SUB_DERIVED = 3'd6,
		OP_SUB_CLEAR   = 3'd7
	} op_t;

	// One table entry as held in the memory.
	typedef struct packed {
		logic                 derived;
		logic                 valid;
		logic [AGE_BITS-1:0]  age;
		logic [ADDR_BITS-1:0] addr;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Classified command passed from the front to the back.
	typedef struct packed {
		op_t                   op;
		logic                  ok;
		logic [IDX_W-1:0]      index;
		logic [IDX_W-1:0]      row;
		logic [ADDR_BITS-1:0]  addr;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_WALK,
		ST_WALK_END,
		ST_FRD,
		ST_FINAL,
		ST_SUB
	} state_t;

endpackage
`default_nettype wire

// File: hdl/nam_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nam_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/nam_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nam_front
// Accepts input items, classifies them into commands and queues them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nam_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    opcode,
	input  wire logic [nam_pkg::SUB_W-1:0]     subnet,
	input  wire logic [nam_pkg::NODE_W-1:0]    node,
	input  wire logic [nam_pkg::OUT_ADDR_W-1:0] address,
	input  wire logic                          clearing,
	output logic                               cmd_valid,
	output nam_pkg::cmd_t                      cmd,
	input  wire logic                          cmd_pop
);

	nam_pkg::cmd_t  mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	nam_pkg::cmd_t  new_cmd;
	logic           push;
	logic           pop;

	// Classify the item: range check and table index.
	always_comb begin
		new_cmd.op    = nam_pkg::op_t'(opcode);
		new_cmd.ok    = (32'(subnet) < 32'(nam_pkg::NUM_SUBNETS)) &&
		                (32'(node) < 32'(nam_pkg::NODES_PER_SUBNET));
		new_cmd.row   = nam_pkg::IDX_W'(32'(subnet) * 32'(nam_pkg::NODES_PER_SUBNET));
		new_cmd.index = nam_pkg::IDX_W'(32'(subnet) * 32'(nam_pkg::NODES_PER_SUBNET)
		                + 32'(node));
		new_cmd.addr  = nam_pkg::ADDR_BITS'(address);
	end

	assign in_stall  = (count_q == 2'd2) || clearing;
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/nam_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nam_back
// Carries out queued commands on the entry memory: single-entry
// read-modify-write, the aging walk, per-subnet sweeps and the reset clear.
// ----------------------------------------------------------------------------
module nam_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	input  wire nam_pkg::cmd_t                   cmd,
	output logic                                 cmd_pop,
	output logic                                 clearing,
	input  wire logic [nam_pkg::LIMIT_W-1:0]     age_limit,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 is_derived,
	output logic                                 has_explicit,
	output logic [nam_pkg::OUT_ADDR_W-1:0]       explicit_address
);

	nam_pkg::state_t              state_q, state_d;
	nam_pkg::cmd_t                cmd_q;
	logic [nam_pkg::IDX_W-1:0]    ptr_q, ptr_d;
	logic [nam_pkg::IDX_W-1:0]    wptr_q;
	logic                         pend_q, pend_d;
	logic [nam_pkg::NODE_CNT_W-1:0] k_q, k_d;
	logic                         load_cmd;
	logic                         wr_en;
	logic [nam_pkg::IDX_W-1:0]    wr_addr;
	nam_pkg::entry_t              wr_data;
	logic                         rd_en;
	logic [nam_pkg::IDX_W-1:0]    rd_addr;
	logic [nam_pkg::ENTRY_W-1:0]  rd_raw;
	nam_pkg::entry_t              rd_data;
	nam_pkg::entry_t              aged;
	nam_pkg::entry_t              modified;
	logic                         out_load;
	nam_pkg::entry_t              out_entry;
	logic                         ptr_last;
	logic [nam_pkg::AGE_BITS-1:0] age_inc;

	assign rd_data  = nam_pkg::entry_t'(rd_raw);
	assign ptr_last = (ptr_q == nam_pkg::IDX_W'(nam_pkg::NUM_ENTRIES - 1));
	assign clearing = (state_q == nam_pkg::ST_CLEAR);

	nam_ram #(
		.WIDTH(nam_pkg::ENTRY_W),
		.DEPTH(nam_pkg::NUM_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(nam_pkg::ENTRY_W'(wr_data)),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// One aging step on the entry just read.
	always_comb begin
		aged    = rd_data;
		age_inc = (rd_data.age < nam_pkg::AGE_MAX) ? rd_data.age + 1'b1 : rd_data.age;
		if (rd_data.valid) begin
			aged.age = age_inc;
			if (nam_pkg::CMP_W'(age_inc) >= nam_pkg::CMP_W'(age_limit)) begin
				aged.valid = 1'b0;
				aged.age   = '0;
				aged.addr  = '0;
			end
		end
	end

	// Single-entry update.
	always_comb begin
		modified = rd_data;
		case (cmd_q.op)
			nam_pkg::OP_SET_DERIVED: begin
				modified = '0;
				modified.derived = 1'b1;
			end
			nam_pkg::OP_CLR_DERIVED: begin
				modified.derived = 1'b0;
			end
			nam_pkg::OP_STORE: begin
				modified.derived = 1'b0;
				modified.valid   = 1'b1;
				modified.age     = '0;
				modified.addr    = cmd_q.addr;
			end
			nam_pkg::OP_CLR_ADDR: begin
				modified.valid = 1'b0;
				modified.age   = '0;
				modified.addr  = '0;
			end
			default: begin
				modified = rd_data;
			end
		endcase
	end

	// Next state, memory control and result load.
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		pend_d    = pend_q;
		k_d       = k_q;
		load_cmd  = 1'b0;
		cmd_pop   = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = ptr_q;
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr   = cmd_q.index;
		out_load  = 1'b0;
		out_entry = '0;
		case (state_q)
			nam_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				ptr_d = ptr_q + 1'b1;
				if (ptr_last) begin
					ptr_d   = '0;
					state_d = nam_pkg::ST_IDLE;
				end
			end
			nam_pkg::ST_IDLE: begin
				// A held result that leaves in this cycle frees the output register.
				if (cmd_valid && (!out_valid || !out_stall)) begin
					cmd_pop  = 1'b1;
					load_cmd = 1'b1;
					rd_addr  = cmd.index;
					if (cmd.op == nam_pkg::OP_AGE_TICK) begin
						ptr_d   = '0;
						pend_d  = 1'b0;
						state_d = nam_pkg::ST_WALK;
					end else if (!cmd.ok) begin
						out_load = 1'b1;
					end else if (cmd.op == nam_pkg::OP_SUB_DERIVED ||
					             cmd.op == nam_pkg::OP_SUB_CLEAR) begin
						k_d     = '0;
						state_d = nam_pkg::ST_SUB;
					end else begin
						rd_en   = 1'b1;
						state_d = nam_pkg::ST_MOD;
					end
				end
			end
			nam_pkg::ST_MOD: begin
				wr_en     = (cmd_q.op != nam_pkg::OP_LOOKUP);
				wr_addr   = cmd_q.index;
				wr_data   = modified;
				out_load  = 1'b1;
				out_entry = modified;
				state_d   = nam_pkg::ST_IDLE;
			end
			nam_pkg::ST_WALK: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q;
				wr_en   = pend_q;
				wr_addr = wptr_q;
				wr_data = aged;
				pend_d  = 1'b1;
				ptr_d   = ptr_q + 1'b1;
				if (ptr_last) begin
					ptr_d   = '0;
					state_d = nam_pkg::ST_WALK_END;
				end
			end
			nam_pkg::ST_WALK_END: begin
				wr_en   = 1'b1;
				wr_addr = wptr_q;
				wr_data = aged;
				pend_d  = 1'b0;
				state_d = nam_pkg::ST_FRD;
			end
			nam_pkg::ST_FRD: begin
				rd_en   = 1'b1;
				state_d = nam_pkg::ST_FINAL;
			end
			nam_pkg::ST_FINAL: begin
				out_load  = cmd_q.ok;
				out_entry = rd_data;
				if (!cmd_q.ok) begin
					out_load  = 1'b1;
					out_entry = '0;
				end
				state_d = nam_pkg::ST_IDLE;
			end
			nam_pkg::ST_SUB: begin
				wr_en           = 1'b1;
				wr_addr         = cmd_q.row + nam_pkg::IDX_W'(k_q);
				wr_data         = '0;
				wr_data.derived = (cmd_q.op == nam_pkg::OP_SUB_DERIVED);
				k_d             = k_q + 1'b1;
				if (k_q == nam_pkg::NODE_CNT_W'(nam_pkg::NODES_PER_SUBNET - 1)) begin
					out_load  = 1'b1;
					out_entry = wr_data;
					state_d   = nam_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nam_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nam_pkg::ST_CLEAR;
			ptr_q     <= '0;
			pend_q    <= 1'b0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			pend_q  <= pend_d;
			k_q     <= k_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Command, walk write pointer and result payload.
	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= cmd;
		end
		wptr_q <= ptr_q;
		if (out_load) begin
			is_derived       <= out_entry.derived;
			has_explicit     <= out_entry.valid;
			explicit_address <= out_entry.valid ?
			                    nam_pkg::OUT_ADDR_W'(out_entry.addr) : '0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/node_address_map_with_aging.sv
`default_nettype none
// ----------------------------------------------------------------------------
// node_address_map_with_aging
// Table of derived flags and aged explicit addresses per subnet and node.
// ----------------------------------------------------------------------------
// A single-entry item is carried out as a memory read, then the write and the
// result; the back end starts the next item only once it is back in idle.
// A subnet operation occupies the back end while it writes one entry per node.
// An age tick walks every entry at one per cycle, then rereads the addressed entry.
// After reset a clearing pass writes all 32768 entries, one per cycle, and no
// item is accepted until it ends; age_limit resets to 4.
module node_address_map_with_aging (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  subnet,
	input  wire logic [6:0]  node,
	input  wire logic [31:0] address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             is_derived,
	output logic             has_explicit,
	output logic [31:0]      explicit_address,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	logic [nam_pkg::LIMIT_W-1:0]     limit_q;
	logic                            cmd_valid;
	nam_pkg::cmd_t                   cmd;
	logic                            cmd_pop;
	logic                            clearing;

	// Age limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= nam_pkg::AGE_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	nam_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.subnet   (subnet),
		.node     (node),
		.address  (address),
		.clearing (clearing),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	nam_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.clearing        (clearing),
		.age_limit       (limit_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.is_derived      (is_derived),
		.has_explicit    (has_explicit),
		.explicit_address(explicit_address)
	);

endmodule
`default_nettype wire

// File: tb/tb_node_address_map_with_aging.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_node_address_map_with_aging
// Self-checking bench for the node address map: a behavioral table model
// predicts every result, and random handshake stalls on both sides are used.
// ----------------------------------------------------------------------------
module tb_node_address_map_with_aging;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [7:0]  subnet;
	logic [6:0]  node;
	logic [31:0] address;
	logic        out_valid;
	logic        out_stall;
	logic        is_derived;
	logic        has_explicit;
	logic [31:0] explicit_address;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	node_address_map_with_aging dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .subnet(subnet), .node(node), .address(address),
		.out_valid(out_valid), .out_stall(out_stall),
		.is_derived(is_derived), .has_explicit(has_explicit),
		.explicit_address(explicit_address),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	typedef struct packed {
		logic        derived;
		logic        valid;
		logic [31:0] addr;
	} entry_view_t;

	// Shadow copy of the table and the aging limit.
	logic                          shadow_derived [nam_pkg::NUM_ENTRIES];
	logic                          shadow_valid [nam_pkg::NUM_ENTRIES];
	logic [nam_pkg::ADDR_BITS-1:0] shadow_addr [nam_pkg::NUM_ENTRIES];
	logic [nam_pkg::AGE_BITS-1:0]  shadow_age [nam_pkg::NUM_ENTRIES];
	logic [7:0]                    shadow_limit;

	entry_view_t expected_entries [$];
	int          mismatch_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hot_valid [nam_pkg::NUM_ENTRIES];
	int          hot_list [$];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Generous end of run: the age ticks dominate the run time.
	initial begin
		#40000000;
		$display("FAIL");
		$finish;
	end

	function automatic void drop_entry(input int e);
		shadow_valid[e] = 1'b0;
		shadow_addr[e]  = '0;
		shadow_age[e]   = '0;
	endfunction

	// Apply one operation to the shadow table and return the reported entry.
	function automatic entry_view_t apply_operation(input nam_pkg::op_t op,
			input logic [7:0] sub, input logic [6:0] nd, input logic [31:0] addr);
		int e;
		int row;
		int a;
		entry_view_t r;
		e   = sub * nam_pkg::NODES_PER_SUBNET + nd;
		row = sub * nam_pkg::NODES_PER_SUBNET;
		case (op)
			nam_pkg::OP_AGE_TICK: begin
				foreach (hot_list[i]) begin
					int h;
					h = hot_list[i];
					if (shadow_valid[h]) begin
						a = shadow_age[h];
						if (a < nam_pkg::AGE_MAX)
							a++;
						shadow_age[h] = a[nam_pkg::AGE_BITS-1:0];
						if (a >= shadow_limit)
							drop_entry(h);
					end
				end
			end
			nam_pkg::OP_SET_DERIVED: begin
				shadow_derived[e] = 1'b1;
				drop_entry(e);
			end
			nam_pkg::OP_CLR_DERIVED: shadow_derived[e] = 1'b0;
			nam_pkg::OP_STORE: begin
				shadow_derived[e] = 1'b0;
				shadow_valid[e]   = 1'b1;
				shadow_addr[e]    = addr;
				shadow_age[e]     = '0;
				if (!hot_valid[e]) begin
					hot_valid[e] = 1'b1;
					hot_list.push_back(e);
				end
			end
			nam_pkg::OP_CLR_ADDR: drop_entry(e);
			nam_pkg::OP_SUB_DERIVED, nam_pkg::OP_SUB_CLEAR: begin
				for (int k = 0; k < nam_pkg::NODES_PER_SUBNET; k++) begin
					shadow_derived[row + k] = (op == nam_pkg::OP_SUB_DERIVED);
					drop_entry(row + k);
				end
			end
			default: ;
		endcase
		r.derived = shadow_derived[e];
		r.valid   = shadow_valid[e];
		r.addr    = shadow_valid[e] ? shadow_addr[e][31:0] : 32'd0;
		return r;
	endfunction

	// Send one transfer and record its expected result once accepted.
	task automatic send_item(input nam_pkg::op_t op, input logic [7:0] sub,
			input logic [6:0] nd, input logic [31:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		subnet   <= sub;
		node     <= nd;
		address  <= addr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_entries.push_back(apply_operation(op, sub, nd, addr));
		@(negedge clk);
	endtask

	// Drain all results, then let a tail of cycles pass before a register write.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_entries.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_age_limit(input logic [7:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		shadow_limit = value;
	endtask

	// Receiver stalls and result checking.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			entry_view_t want;
			if (expected_entries.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: derived=%0b valid=%0b addr=%h",
						is_derived, has_explicit, explicit_address);
			end else begin
				want = expected_entries.pop_front();
				if (want.derived !== is_derived || want.valid !== has_explicit ||
						want.addr !== explicit_address) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %0b/%0b/%h, got %0b/%0b/%h",
							want.derived, want.valid, want.addr,
							is_derived, has_explicit, explicit_address);
				end
			end
		end
	end

	// Single-entry operations, mostly on the extremes of the fields.
	task automatic test_entry_ops();
		send_item(nam_pkg::OP_LOOKUP, 8'd0, 7'd0, 32'd0);
		send_item(nam_pkg::OP_STORE, 8'd255, 7'd127, 32'hFFFF_FFFF);
		send_item(nam_pkg::OP_LOOKUP, 8'd255, 7'd127, 32'd0);
		send_item(nam_pkg::OP_STORE, 8'd255, 7'd127, 32'hFFFF_FFFF);
		send_item(nam_pkg::OP_SET_DERIVED, 8'd255, 7'd127, 32'h5555_AAAA);
		send_item(nam_pkg::OP_STORE, 8'd0, 7'd0, 32'h0000_0000);
		send_item(nam_pkg::OP_CLR_DERIVED, 8'd255, 7'd127, 32'd0);
		send_item(nam_pkg::OP_SET_DERIVED, 8'd0, 7'd1, 32'd0);
		send_item(nam_pkg::OP_CLR_ADDR, 8'd0, 7'd1, 32'd0);
		send_item(nam_pkg::OP_CLR_ADDR, 8'd0, 7'd0, 32'd0);
		send_item(nam_pkg::OP_STORE, 8'd1, 7'd2, 32'hAAAA_5555);
	endtask

	// Aging with the reset limit, a stored address refreshed, and the extremes.
	task automatic test_aging();
		send_item(nam_pkg::OP_STORE, 8'd3, 7'd4, 32'h1234_5678);
		send_item(nam_pkg::OP_AGE_TICK, 8'd3, 7'd4, 32'd0);
		send_item(nam_pkg::OP_STORE, 8'd3, 7'd4, 32'h1234_5678);
		repeat (4) send_item(nam_pkg::OP_AGE_TICK, 8'd3, 7'd4, 32'd0);
		write_age_limit(8'd1);
		send_item(nam_pkg::OP_STORE, 8'd7, 7'd9, 32'hCAFE_0001);
		send_item(nam_pkg::OP_AGE_TICK, 8'd7, 7'd9, 32'd0);
		write_age_limit(8'd255);
		send_item(nam_pkg::OP_STORE, 8'd7, 7'd9, 32'hCAFE_0002);
		send_item(nam_pkg::OP_AGE_TICK, 8'd7, 7'd9, 32'd0);
	endtask

	// Whole-subnet operations on the lowest and highest subnets.
	task automatic test_subnet_ops();
		send_item(nam_pkg::OP_STORE, 8'd255, 7'd5, 32'h0BAD_F00D);
		send_item(nam_pkg::OP_SUB_DERIVED, 8'd255, 7'd5, 32'd0);
		send_item(nam_pkg::OP_LOOKUP, 8'd255, 7'd127, 32'd0);
		send_item(nam_pkg::OP_STORE, 8'd0, 7'd64, 32'hDEAD_BEEF);
		send_item(nam_pkg::OP_SUB_CLEAR, 8'd0, 7'd3, 32'd0);
		send_item(nam_pkg::OP_LOOKUP, 8'd0, 7'd64, 32'd0);
	endtask

	// Random traffic, mostly over a small set of subnets so entries get reused and aged.
	task automatic test_random(input int count, input logic [7:0] limit);
		nam_pkg::op_t op;
		logic [7:0]   sub;
		logic [6:0]   nd;
		int           pick;
		write_age_limit(limit);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 30)       op = nam_pkg::OP_STORE;
			else if (pick < 50)  op = nam_pkg::OP_LOOKUP;
			else if (pick < 60)  op = nam_pkg::OP_SET_DERIVED;
			else if (pick < 70)  op = nam_pkg::OP_CLR_DERIVED;
			else if (pick < 80)  op = nam_pkg::OP_CLR_ADDR;
			else if (pick < 88)  op = nam_pkg::OP_AGE_TICK;
			else if (pick < 94)  op = nam_pkg::OP_SUB_DERIVED;
			else                 op = nam_pkg::OP_SUB_CLEAR;
			if ($urandom_range(3) == 0) begin
				sub = 8'($urandom);
				nd  = 7'($urandom);
			end else begin
				sub = {$urandom_range(1) ? 8'hFF : 8'h00} ^ 8'($urandom_range(3));
				nd  = {$urandom_range(1) ? 7'h7F : 7'h00} ^ 7'($urandom_range(7));
			end
			send_item(op, sub, nd, $urandom);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_stall = 1'b0;
		opcode    = '0;
		subnet    = '0;
		node      = '0;
		address   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		mismatch_count = 0;
		shadow_limit   = nam_pkg::AGE_LIMIT_RESET;
		send_idle_pct  = 21;
		recv_idle_pct  = 72;
		for (int e = 0; e < nam_pkg::NUM_ENTRIES; e++) begin
			shadow_derived[e] = 1'b0;
			shadow_valid[e]   = 1'b0;
			shadow_addr[e]    = '0;
			shadow_age[e]     = '0;
			hot_valid[e]      = 1'b0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_entry_ops();
		test_aging();
		test_subnet_ops();
		// Hold off until the pipeline is empty before continuing.
		wait_drained();
		test_random(230, 8'd2);
		send_idle_pct = 72;
		recv_idle_pct = 21;
		test_random(230, 8'd3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(230, 8'd4);

		wait_drained();
		if (mismatch_count == 0 && expected_entries.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
hdl/nam_pkg.sv
hdl/nam_ram.sv
hdl/nam_front.sv
hdl/nam_back.sv
hdl/node_address_map_with_aging.sv
tb/tb_node_address_map_with_aging.sv
